// File: hw/rtl/bhc_pkg.sv
`default_nettype none

package bhc_pkg;

    // input commands
    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_ADD   = 2'd2,
        CMD_DUMP  = 2'd3
    } cmd_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_STORED    = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_NULL_BND  = 3'd3,
        ST_ENTRY     = 3'd4,
        ST_EMPTY     = 3'd5,
        ST_LOCKED    = 3'd6
    } status_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,
        S_SRCH_CMP,
        S_MATCH,
        S_SHIFT,
        S_SHIFT_WR,
        S_INC,
        S_DUMP_OVF,
        S_DUMP_RD,
        S_DUMP_OUT,
        S_RESULT
    } state_t;

    // shared compare unit result
    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_res_t;

    localparam logic signed [31:0] OVF_KEY = 32'sh7FFF_FFFF;
    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

// File: hw/rtl/bhc_ram.sv
`default_nettype none

// simple dual-port RAM, registered read, read data holds when re is low
module bhc_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32,
    parameter int AW    = 5
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/bhc_cmp.sv
`default_nettype none

// shared compare unit: signed less-than / equal, plus saturating count increment
module bhc_cmp (
    input  wire logic signed [31:0] a,
    input  wire logic signed [31:0] b,
    input  wire logic        [31:0] cnt,
    output bhc_pkg::cmp_res_t       res,
    output logic             [31:0] cnt_inc
);

    import bhc_pkg::*;

    always_comb begin
        res.lt  = (a < b);
        res.eq  = (a == b);
        cnt_inc = (cnt == CNT_MAX) ? cnt : cnt + 32'd1;
    end

endmodule

`default_nettype wire

// File: hw/rtl/binned_histogram_counter_unit.sv
`default_nettype none

// Binned histogram counter. Holds a sorted, duplicate-free table of up to
// MAX_BOUNDARIES signed boundaries and one saturating 32-bit count per bin plus
// an overflow bin. Commands: clear (no result), load boundary (one result with
// a status), add sample (no result), dump (one entry per boundary, then the
// overflow bin if nonzero, or a single empty marker if no sample was ever
// counted). Boundaries lock once the first sample is counted. exact_mode
// selects exact-match binning and may only be written while the block is idle.
// Timing: s_ready is high only while the sequencer is idle; one item is worked
// on at a time. Lookups are a binary search through the boundary RAM, each step
// a read and then a compare, with about log2(used+1) steps. An add sample then
// reads the bin count and writes it back incremented. A stored load shifts
// each boundary above the insert point up one slot (read, then write) to make
// room; a duplicate or full load ends after the search, a null or locked load
// skips it. Dump reads each boundary and its count in turn and can be held up
// by m_ready back-pressure. A result waits in the output register, so the next
// transfer in can be accepted while it is pending.
module binned_histogram_counter_unit #(
    parameter int MAX_BOUNDARIES = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_wdata,
    // input channel
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire bhc_pkg::cmd_t         s_command,
    input  wire logic signed [31:0]    s_operand_value,
    input  wire logic                  s_value_is_null,
    // result channel
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output bhc_pkg::status_t           m_status,
    output logic signed [31:0]         m_bin_key,
    output logic        [31:0]         m_bin_total,
    output logic                       m_is_other,
    output logic                       m_last
);

    import bhc_pkg::*;

    // table address width and bin/count index width
    localparam int TAW = (MAX_BOUNDARIES > 1) ? $clog2(MAX_BOUNDARIES) : 1;
    localparam int CW  = $clog2(MAX_BOUNDARIES + 1);
    localparam logic [CW-1:0] MAXB = CW'(MAX_BOUNDARIES);

    // ---------------------------------------------------------------------
    // State
    // ---------------------------------------------------------------------
    state_t                  state_reg, state_next;
    cmd_t                    cmd_reg, cmd_next;
    logic signed [31:0]      val_reg, val_next;
    logic [CW-1:0]           lo_reg, lo_next;
    logic [CW-1:0]           hi_reg, hi_next;
    logic [CW-1:0]           idx_reg, idx_next;   // shift / dump pointer
    logic [CW-1:0]           bin_reg, bin_next;
    logic [31:0]             ovf_reg, ovf_next;   // overflow count snapshot for dump
    status_t                 res_status_reg, res_status_next;
    logic signed [31:0]      res_key_reg, res_key_next;

    logic [CW-1:0]           used_reg, used_next;
    logic                    seen_reg, seen_next;
    logic [MAX_BOUNDARIES:0] cnt_vld_reg, cnt_vld_next;  // count entry written since clear
    logic                    exact_mode_reg;
    logic                    cvld_rd_reg;                // valid bit of the last count read

    // output register
    logic                    m_valid_reg, m_valid_next;
    status_t                 m_status_reg;
    logic signed [31:0]      m_key_reg;
    logic [31:0]             m_count_reg;
    logic                    m_other_reg;
    logic                    m_last_reg;

    // memory ports
    logic                    t_we, t_re;
    logic [TAW-1:0]          t_waddr, t_raddr;
    logic signed [31:0]      t_wdata;
    logic [31:0]             t_rdata;
    logic                    c_we, c_re;
    logic [CW-1:0]           c_waddr, c_raddr;
    logic [31:0]             c_wdata, c_rdata;

    // result emit
    logic                    emit;
    status_t                 e_status;
    logic signed [31:0]      e_key;
    logic [31:0]             e_count;
    logic                    e_other;
    logic                    e_last;

    logic                    s_xfer;
    logic                    out_free;
    logic [CW-1:0]           mid;
    logic [31:0]             cnt_eff;
    logic [31:0]             cnt_inc;
    cmp_res_t                cmp;
    logic                    hit;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_xfer   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign cnt_eff  = cvld_rd_reg ? c_rdata : 32'd0;
    assign hit      = cmp.eq && (lo_reg < used_reg);

    // ---------------------------------------------------------------------
    // Storage and shared compare unit
    // ---------------------------------------------------------------------
    bhc_ram #(
        .DEPTH (MAX_BOUNDARIES),
        .WIDTH (32),
        .AW    (TAW)
    ) u_bnd_ram (
        .aclk  (aclk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .re    (t_re),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    bhc_ram #(
        .DEPTH (MAX_BOUNDARIES + 1),
        .WIDTH (32),
        .AW    (CW)
    ) u_cnt_ram (
        .aclk  (aclk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .re    (c_re),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    bhc_cmp u_cmp (
        .a       (t_rdata),
        .b       (val_reg),
        .cnt     (cnt_eff),
        .res     (cmp),
        .cnt_inc (cnt_inc)
    );

    // ---------------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    case (s_command)
                        CMD_CLEAR: state_next = S_IDLE;
                        CMD_LOAD: begin
                            if (s_value_is_null || seen_reg) begin
                                state_next = S_RESULT;
                            end else begin
                                state_next = S_SRCH;
                            end
                        end
                        CMD_ADD:  state_next = s_value_is_null ? S_IDLE : S_SRCH;
                        CMD_DUMP: state_next = seen_reg ? S_DUMP_OVF : S_RESULT;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_SRCH:     state_next = (lo_reg < hi_reg) ? S_SRCH_CMP : S_MATCH;
            S_SRCH_CMP: state_next = S_SRCH;
            S_MATCH: begin
                if (cmd_reg == CMD_ADD) begin
                    state_next = S_INC;
                end else if (hit || used_reg >= MAXB) begin
                    state_next = S_RESULT;
                end else begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:    state_next = (idx_reg > lo_reg) ? S_SHIFT_WR : S_RESULT;
            S_SHIFT_WR: state_next = S_SHIFT;
            S_INC:      state_next = S_IDLE;
            S_DUMP_OVF: state_next = S_DUMP_RD;
            S_DUMP_RD: begin
                if (idx_reg < used_reg) begin
                    state_next = S_DUMP_OUT;
                end else if (ovf_reg != 32'd0 || used_reg == '0) begin
                    if (out_free) begin
                        state_next = S_IDLE;
                    end
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_DUMP_OUT: begin
                if (out_free) begin
                    state_next = S_DUMP_RD;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------
    // Datapath control
    // ---------------------------------------------------------------------
    always_comb begin
        cmd_next        = cmd_reg;
        val_next        = val_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        idx_next        = idx_reg;
        bin_next        = bin_reg;
        ovf_next        = ovf_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        used_next       = used_reg;
        seen_next       = seen_reg;
        cnt_vld_next    = cnt_vld_reg;

        t_we    = 1'b0;
        t_waddr = '0;
        t_wdata = val_reg;
        t_re    = 1'b0;
        t_raddr = '0;
        c_we    = 1'b0;
        c_waddr = bin_reg;
        c_wdata = cnt_inc;
        c_re    = 1'b0;
        c_raddr = '0;

        emit     = 1'b0;
        e_status = res_status_reg;
        e_key    = res_key_reg;
        e_count  = 32'd0;
        e_other  = 1'b0;
        e_last   = 1'b1;

        case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    cmd_next     = s_command;
                    val_next     = s_operand_value;
                    lo_next      = '0;
                    hi_next      = used_reg;
                    res_key_next = s_operand_value;
                    case (s_command)
                        CMD_CLEAR: begin
                            used_next    = '0;
                            seen_next    = 1'b0;
                            cnt_vld_next = '0;
                        end
                        CMD_LOAD: begin
                            res_status_next = s_value_is_null ? ST_NULL_BND : ST_LOCKED;
                        end
                        CMD_DUMP: begin
                            res_status_next = ST_EMPTY;
                            res_key_next    = '0;
                            c_re            = 1'b1;
                            c_raddr         = used_reg;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SRCH: begin
                t_re = 1'b1;
                // at the end of the search, fetch the candidate for the equality test
                t_raddr = (lo_reg < hi_reg) ? mid[TAW-1:0] : lo_reg[TAW-1:0];
            end
            S_SRCH_CMP: begin
                if (cmp.lt) begin
                    lo_next = mid + CW'(1);
                end else begin
                    hi_next = mid;
                end
            end
            S_MATCH: begin
                if (cmd_reg == CMD_ADD) begin
                    bin_next = (exact_mode_reg && !hit) ? used_reg : lo_reg;
                    c_re     = 1'b1;
                    c_raddr  = bin_next;
                end else if (hit) begin
                    res_status_next = ST_DUPLICATE;
                end else if (used_reg >= MAXB) begin
                    res_status_next = ST_FULL;
                end else begin
                    idx_next = used_reg;
                end
            end
            S_SHIFT: begin
                if (idx_reg > lo_reg) begin
                    t_re    = 1'b1;
                    t_raddr = TAW'(idx_reg - CW'(1));
                end else begin
                    t_we            = 1'b1;
                    t_waddr         = lo_reg[TAW-1:0];
                    t_wdata         = val_reg;
                    used_next       = used_reg + CW'(1);
                    res_status_next = ST_STORED;
                end
            end
            S_SHIFT_WR: begin
                t_we     = 1'b1;
                t_waddr  = idx_reg[TAW-1:0];
                t_wdata  = t_rdata;
                idx_next = idx_reg - CW'(1);
            end
            S_INC: begin
                c_we                  = 1'b1;
                c_waddr               = bin_reg;
                c_wdata               = cnt_inc;
                cnt_vld_next[bin_reg] = 1'b1;
                seen_next             = 1'b1;
            end
            S_DUMP_OVF: begin
                ovf_next = cnt_eff;
                idx_next = '0;
            end
            S_DUMP_RD: begin
                if (idx_reg < used_reg) begin
                    t_re    = 1'b1;
                    t_raddr = idx_reg[TAW-1:0];
                    c_re    = 1'b1;
                    c_raddr = idx_reg;
                end else if (ovf_reg != 32'd0) begin
                    emit     = out_free;
                    e_status = ST_ENTRY;
                    e_key    = OVF_KEY;
                    e_count  = ovf_reg;
                    e_other  = 1'b1;
                end else if (used_reg == '0) begin
                    // nothing to list
                    emit     = out_free;
                    e_status = ST_EMPTY;
                    e_key    = '0;
                end
            end
            S_DUMP_OUT: begin
                emit     = out_free;
                e_status = ST_ENTRY;
                e_key    = t_rdata;
                e_count  = cnt_eff;
                e_last   = (idx_reg + CW'(1) == used_reg) && (ovf_reg == 32'd0);
                if (out_free) begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_RESULT: begin
                emit = out_free;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            seen_reg       <= 1'b0;
            cnt_vld_reg    <= '0;
            exact_mode_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            seen_reg    <= seen_next;
            cnt_vld_reg <= cnt_vld_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                exact_mode_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        val_reg        <= val_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        idx_reg        <= idx_next;
        bin_reg        <= bin_next;
        ovf_reg        <= ovf_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        if (c_re) begin
            cvld_rd_reg <= cnt_vld_reg[c_raddr];
        end
        if (emit) begin
            m_status_reg <= e_status;
            m_key_reg    <= e_key;
            m_count_reg  <= e_count;
            m_other_reg  <= e_other;
            m_last_reg   <= e_last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_bin_key   = m_key_reg;
    assign m_bin_total = m_count_reg;
    assign m_is_other  = m_other_reg;
    assign m_last      = m_last_reg;

endmodule

`default_nettype wire

// File: tb/sv/binned_histogram_counter_unit_tb.sv
`timescale 1ns / 1ps

module binned_histogram_counter_unit_tb;
    import bhc_pkg::*;

    localparam int MAX_BND       = 32;
    // Quiet cycles let after the last result before a mode write or the end.
    localparam int SETTLE_CYCLES = 120;
    // Watchdog: cycles with no transfer on either channel.
    localparam int STALL_LIMIT   = 5000;

    // One expected entry on the result channel.
    typedef struct {
        status_t            status;
        logic signed [31:0] key;
        logic [31:0]        count;
        logic               other;
        logic               last;
    } bin_report_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic               cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    cmd_t               s_command;
    logic signed [31:0] s_operand_value;
    logic               s_value_is_null;
    logic               m_valid;
    logic               m_ready = 1'b0;
    status_t            m_status;
    logic signed [31:0] m_bin_key;
    logic [31:0]        m_bin_total;
    logic               m_is_other;
    logic               m_last;

    // Shadow copy of the histogram, updated at each accepted input transfer.
    logic signed [31:0] bnd_table [MAX_BND];
    int                 bnd_used;
    logic [31:0]        bin_tally [MAX_BND + 1];
    bit                 sample_locked;
    bit                 exact_sel;

    // Entries still owed by the block, oldest first.
    bin_report_t        pending_reports[$];

    int fail_count      = 0;
    int items_sent      = 0;
    int reports_checked = 0;
    int mode_writes     = 0;
    int full_hits       = 0;
    int locked_hits     = 0;
    int quiet_cycles    = 0;

    // Idle profile, percent of cycles: sender gap / receiver stall.
    int send_idle_pct   = 27;
    int recv_stall_pct  = 69;

    binned_histogram_counter_unit #(
        .MAX_BOUNDARIES(MAX_BND)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_operand_value(s_operand_value),
        .s_value_is_null(s_value_is_null),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_bin_key      (m_bin_key),
        .m_bin_total    (m_bin_total),
        .m_is_other     (m_is_other),
        .m_last         (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Histogram predictor
    // ------------------------------------------------------------------

    // Binary search: first slot whose boundary is not below v.
    function automatic int first_not_below(logic signed [31:0] v);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = bnd_used;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (bnd_table[mid] < v) lo = mid + 1;
            else hi = mid;
        end
        return lo;
    endfunction

    function automatic void clear_histogram();
        for (int i = 0; i < MAX_BND; i++) bnd_table[i] = '0;
        for (int i = 0; i <= MAX_BND; i++) bin_tally[i] = '0;
        bnd_used      = 0;
        sample_locked = 1'b0;
    endfunction

    function automatic void push_report(status_t st, logic signed [31:0] key,
                                        logic [31:0] cnt, logic oth, logic lst);
        bin_report_t r;
        r.status = st;
        r.key    = key;
        r.count  = cnt;
        r.other  = oth;
        r.last   = lst;
        pending_reports.insert(pending_reports.size(), r);
    endfunction

    // Apply one accepted command to the shadow state and queue what it emits.
    function automatic void predict_command(cmd_t c, logic signed [31:0] v, logic n);
        int      pos;
        int      bin;
        bit      emitted;
        status_t st;
        case (c)
            CMD_CLEAR: clear_histogram();   // mode bit survives a clear
            CMD_LOAD: begin
                // priority: null, locked, duplicate, full, stored
                if (n) begin
                    st = ST_NULL_BND;
                end else if (sample_locked) begin
                    st = ST_LOCKED;
                    locked_hits++;
                end else begin
                    pos = first_not_below(v);
                    if (pos < bnd_used && bnd_table[pos] == v) begin
                        st = ST_DUPLICATE;
                    end else if (bnd_used >= MAX_BND) begin
                        st = ST_FULL;
                        full_hits++;
                    end else begin
                        for (int i = bnd_used; i > pos; i--) bnd_table[i] = bnd_table[i - 1];
                        bnd_table[pos] = v;
                        bnd_used++;
                        st = ST_STORED;
                    end
                end
                push_report(st, v, '0, 1'b0, 1'b1);
            end
            CMD_ADD: begin
                // null samples vanish and do not lock the table
                if (!n) begin
                    bin = first_not_below(v);
                    // exact mode: anything but an equal boundary is overflow
                    if (exact_sel && (bin >= bnd_used || bnd_table[bin] != v)) bin = bnd_used;
                    if (bin_tally[bin] != CNT_MAX) bin_tally[bin]++;
                    sample_locked = 1'b1;
                end
            end
            CMD_DUMP: begin
                emitted = 1'b0;
                if (sample_locked) begin
                    for (int i = 0; i < bnd_used; i++) begin
                        push_report(ST_ENTRY, bnd_table[i], bin_tally[i], 1'b0,
                                    (i == bnd_used - 1) && (bin_tally[bnd_used] == 0));
                        emitted = 1'b1;
                    end
                    // overflow bin only shows up when it holds something
                    if (bin_tally[bnd_used] != 0) begin
                        push_report(ST_ENTRY, OVF_KEY, bin_tally[bnd_used], 1'b1, 1'b1);
                        emitted = 1'b1;
                    end
                end
                if (!emitted) push_report(ST_EMPTY, '0, '0, 1'b0, 1'b1);
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checker: each transfer out against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_results
        bin_report_t want;
        if (aresetn && m_valid && m_ready) begin
            reports_checked++;
            if (pending_reports.size() == 0) begin
                $error("result with nothing expected: status %0d key %0d total %0d",
                       m_status, m_bin_key, m_bin_total);
                fail_count++;
            end else begin
                want = pending_reports.pop_front();
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    fail_count++;
                end
                if (m_bin_key !== want.key) begin
                    $error("bin_key: expected %0d, got %0d", want.key, m_bin_key);
                    fail_count++;
                end
                if (m_bin_total !== want.count) begin
                    $error("bin_total: expected %0d, got %0d", want.count, m_bin_total);
                    fail_count++;
                end
                if (m_is_other !== want.other) begin
                    $error("is_other: expected %0d, got %0d", want.other, m_is_other);
                    fail_count++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_last);
                    fail_count++;
                end
            end
        end
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: give up when neither channel moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $error("no transfer for %0d cycles, %0d results outstanding",
                   quiet_cycles, pending_reports.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // One input transfer. Entered and left on a rising edge; valid stays up
    // after acceptance so back-to-back items never toggle it within a step.
    task automatic send_item(input cmd_t c, input logic signed [31:0] v, input logic n);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid         <= 1'b1;
        s_command       <= c;
        s_operand_value <= v;
        s_value_is_null <= n;
        do @(posedge aclk); while (!s_ready);
        predict_command(c, v, n);
        items_sent++;
    endtask

    // Hold the sender until every owed result is out, then idle a while.
    // Always advances at least one edge so valid is not driven twice in a step.
    task automatic wait_for_results(input int extra);
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_reports.size() != 0);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic set_exact_mode(input bit m);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        exact_sel = m;
        mode_writes++;
    endtask

    // Mode writes only once the block has gone quiet.
    task automatic reconfigure(input bit m);
        wait_for_results(SETTLE_CYCLES);
        set_exact_mode(m);
    endtask

    function automatic logic signed [31:0] pick_boundary();
        case ($urandom_range(3))
            0:       return $urandom;
            1, 2:    return $signed($urandom_range(200)) - 100;
            default: return $urandom_range(1) ? OVF_KEY : 32'sh8000_0000;
        endcase
    endfunction

    // Samples cluster on and next to existing boundaries to hit the edges.
    function automatic logic signed [31:0] pick_sample();
        logic signed [31:0] anchor;
        anchor = (bnd_used > 0) ? bnd_table[$urandom_range(bnd_used - 1)] : pick_boundary();
        case ($urandom_range(6))
            0, 1:    return anchor;
            2:       return anchor + 1;
            3:       return anchor - 1;
            4:       return $urandom;
            5:       return $signed($urandom_range(200)) - 100;
            default: return $urandom_range(1) ? OVF_KEY : 32'sh8000_0000;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Dump before any sample, and a null sample must not count as one.
    task automatic test_empty_dump();
        send_item(CMD_DUMP, 32'sd0, 1'b0);
        send_item(CMD_ADD, 32'sd17, 1'b1);
        send_item(CMD_DUMP, 32'sd0, 1'b0);
    endtask

    // Every load status except locked and full; extremes of the key range.
    task automatic test_boundary_load();
        send_item(CMD_LOAD, 32'sd5, 1'b1);
        send_item(CMD_LOAD, 32'sh8000_0000, 1'b0);
        send_item(CMD_LOAD, OVF_KEY, 1'b0);
        send_item(CMD_LOAD, 32'sd0, 1'b0);
        send_item(CMD_LOAD, 32'sd0, 1'b0);
        send_item(CMD_LOAD, -32'sd5, 1'b0);
    endtask

    // Lower-bound binning over the table above; nothing lands in overflow.
    task automatic test_range_binning();
        send_item(CMD_ADD, 32'sh8000_0000, 1'b0);
        send_item(CMD_ADD, -32'sd6, 1'b0);
        send_item(CMD_ADD, -32'sd5, 1'b0);
        send_item(CMD_ADD, 32'sd1, 1'b0);
        send_item(CMD_ADD, OVF_KEY, 1'b0);
        send_item(CMD_LOAD, 32'sd3, 1'b0);   // table is locked by now
        wait_for_results(0);                 // hold off before the dump
        send_item(CMD_DUMP, 32'sd0, 1'b0);
    endtask

    // Sample into an empty table goes to overflow; clear drops the lock.
    task automatic test_empty_table_sample();
        send_item(CMD_CLEAR, 32'sd0, 1'b0);
        send_item(CMD_ADD, 32'sd42, 1'b0);
        send_item(CMD_DUMP, 32'sd0, 1'b0);
        send_item(CMD_CLEAR, 32'sd0, 1'b0);
        send_item(CMD_DUMP, 32'sd0, 1'b0);
    endtask

    // Exact mode: only an equal key hits, the rest go to overflow.
    task automatic test_exact_binning();
        reconfigure(1'b1);
        send_item(CMD_CLEAR, 32'sd0, 1'b0);
        send_item(CMD_LOAD, 32'sd10, 1'b0);
        send_item(CMD_ADD, 32'sd10, 1'b0);
        send_item(CMD_ADD, 32'sd9, 1'b0);
        send_item(CMD_DUMP, 32'sd0, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Random traffic
    // ------------------------------------------------------------------

    // Well-formed session: clear, load, add, maybe a late load, dump.
    // About one in ten overfills the table with wide random keys.
    task automatic run_histogram_session();
        int n_bnd;
        int n_smp;
        bit wide;
        wide  = ($urandom_range(9) == 0);
        n_bnd = wide ? $urandom_range(33, 40) : $urandom_range(0, 6);
        n_smp = $urandom_range(1, 12);
        send_item(CMD_CLEAR, $urandom, $urandom_range(1));
        repeat (n_bnd) begin
            case ($urandom_range(9))
                0:       send_item(CMD_LOAD, $urandom, 1'b1);
                1:       send_item(CMD_LOAD, pick_sample(), 1'b0);   // likely a duplicate
                default: send_item(CMD_LOAD, wide ? $urandom : pick_boundary(), 1'b0);
            endcase
        end
        repeat (n_smp) begin
            if ($urandom_range(11) == 0) send_item(CMD_ADD, $urandom, 1'b1);
            else send_item(CMD_ADD, pick_sample(), 1'b0);
        end
        if ($urandom_range(2) == 0) send_item(CMD_LOAD, pick_boundary(), $urandom_range(4) == 0);
        if ($urandom_range(3) == 0) wait_for_results(0);
        send_item(CMD_DUMP, $urandom, $urandom_range(1));
    endtask

    // Unstructured commands on whatever state is left over.
    task automatic run_noise_burst();
        repeat ($urandom_range(1, 6)) begin
            send_item(cmd_t'($urandom_range(3)), $urandom, $urandom_range(3) == 0);
        end
    endtask

    task automatic run_random_phase(input int s_pct, input int r_pct, input bit mode,
                                    input int n_items);
        int start;
        reconfigure(mode);
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        start = items_sent;
        while (items_sent - start < n_items) begin
            if ($urandom_range(4) == 0) run_noise_burst();
            else run_histogram_session();
            // occasional mode flip mid-phase, always from a quiet block
            if ($urandom_range(7) == 0) reconfigure(!exact_sel);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= 1'b0;
        s_valid         <= 1'b0;
        s_command       <= CMD_CLEAR;
        s_operand_value <= '0;
        s_value_is_null <= 1'b0;
        clear_histogram();
        exact_sel = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_exact_mode(1'b0);

        test_empty_dump();
        test_boundary_load();
        test_range_binning();
        test_empty_table_sample();
        test_exact_binning();

        // sender sparse / receiver busy, then swapped, then full rate
        run_random_phase(27, 69, 1'b0, 115);
        run_random_phase(69, 27, 1'b1, 115);
        run_random_phase(0, 0, $urandom_range(1), 115);

        wait_for_results(SETTLE_CYCLES);

        $display("Run covered %0d input transfers and %0d checked results in both modes",
                 items_sent, reports_checked);
        $display("(%0d mode writes, %0d loads into a full table, %0d loads after lock)",
                 mode_writes, full_hits, locked_hits);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/bhc_pkg.sv
hw/rtl/bhc_ram.sv
hw/rtl/bhc_cmp.sv
hw/rtl/binned_histogram_counter_unit.sv
tb/sv/binned_histogram_counter_unit_tb.sv
